[rtl/leb_pkg.sv]
// Shared types and constants for the line edit buffer.
`default_nettype none
package leb_pkg;

  localparam int CHAR_W = 8;
  localparam int LEN_W  = 7;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_WR   = 2'd3;

  typedef struct packed {
    logic [3:0]        cmd;
    logic [CHAR_W-1:0] key_char;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_value;
    logic              char_valid;
    logic              is_last;
    logic [LEN_W-1:0]  cursor_pos;
    logic [LEN_W-1:0]  text_length;
    logic              overwrite_mode;
    logic              finished;
    logic              cancelled;
  } out_req_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [LEN_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/leb_cell.sv]
// One character cell of the line chain.
`default_nettype none
module leb_cell #(
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire leb_pkg::cell_ctl_t        ctl,
  input  wire logic [leb_pkg::CHAR_W-1:0] left_q,
  input  wire logic [leb_pkg::CHAR_W-1:0] right_q,
  output logic      [leb_pkg::CHAR_W-1:0] q
);
  import leb_pkg::*;

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [CHAR_W-1:0] q_r;
  logic [CHAR_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.op)
      OP_INS: begin
        if (MY_IDX > ctl.pos) q_nxt = left_q;
        else if (MY_IDX == ctl.pos) q_nxt = ctl.ch;
      end
      OP_DEL: begin
        if (MY_IDX >= ctl.pos) q_nxt = right_q;
      end
      OP_WR: begin
        if (MY_IDX == ctl.pos) q_nxt = ctl.ch;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

[rtl/leb_chain.sv]
// Row of character cells; delete at position zero rotates the whole row.
`default_nettype none
module leb_chain #(
  parameter int LINE_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire leb_pkg::cell_ctl_t        ctl,
  output logic      [leb_pkg::CHAR_W-1:0] head
);
  import leb_pkg::*;

  logic [CHAR_W-1:0] cq [LINE_DEPTH];

  for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
    localparam int LI = (i == 0) ? 0 : i - 1;
    localparam int RI = (i == LINE_DEPTH - 1) ? 0 : i + 1;
    leb_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_q  (cq[LI]),
      .right_q (cq[RI]),
      .q       (cq[i])
    );
  end

  assign head = cq[0];

endmodule
`default_nettype wire

[rtl/line_edit_buffer.sv]
// Line edit buffer top level: key event decode, sequencer and output register.
//
//   channel | direction | handshake                | payload
//   in_     | input     | in_valid / in_ready      | in_data  (cmd, key_char)
//   out_    | output    | out_valid / out_ready    | out_data (one character per transfer)
//   cfg_    | input     | cfg_we                   | cfg_wdata (max_length)
//
// On a request the edit happens in the cell chain on the accept cycle, then the
// chain rotates once per cycle, unless stalled, for LINE_DEPTH steps, the head
// cell feeding the output register on the first max(length,1) steps.
// A stalled output holds the rotation on emitting steps only.
// Synchronous reset clears length, cursor, mode and sequencer, and sets the limit
// to 64; cell contents are not reset.
`default_nettype none
module line_edit_buffer #(
  parameter int LINE_DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire leb_pkg::in_req_t         in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output leb_pkg::out_req_t             out_data,
  input  wire logic                     cfg_we,
  input  wire logic [leb_pkg::LEN_W-1:0] cfg_wdata
);
  import leb_pkg::*;

  localparam int KW = $clog2(LINE_DEPTH);
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LINE_DEPTH);
  localparam logic [KW-1:0]    K_LAST  = KW'(LINE_DEPTH - 1);

  localparam logic [3:0] CMD_CHAR  = 4'd0;
  localparam logic [3:0] CMD_LEFT  = 4'd1;
  localparam logic [3:0] CMD_RIGHT = 4'd2;
  localparam logic [3:0] CMD_HOME  = 4'd3;
  localparam logic [3:0] CMD_END   = 4'd4;
  localparam logic [3:0] CMD_BKSP  = 4'd5;
  localparam logic [3:0] CMD_DEL   = 4'd6;
  localparam logic [3:0] CMD_MODE  = 4'd7;
  localparam logic [3:0] CMD_ESC   = 4'd8;
  localparam logic [3:0] CMD_ENTER = 4'd9;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROT  = 1'b1;

  logic             st_r, st_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cur_r, cur_nxt;
  logic             mode_r, mode_nxt;
  logic [LEN_W-1:0] maxlen_r;
  logic [LEN_W-1:0] mlen_r, mlen_nxt;
  logic [LEN_W-1:0] mcur_r, mcur_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             mmode_r, mmode_nxt;
  logic             mfin_r, mfin_nxt;
  logic             mcan_r, mcan_nxt;
  logic             oval_r, oval_nxt;
  out_req_t         odat_r, odat_nxt;

  cell_ctl_t         ctl;
  logic [CHAR_W-1:0] head;
  logic              in_fire;
  logic [LEN_W-1:0]  lim;
  logic              emit_step;
  logic              adv;

  leb_chain #(.LINE_DEPTH(LINE_DEPTH)) u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign lim       = (maxlen_r > DEPTH_L) ? DEPTH_L : maxlen_r;
  assign emit_step = (LEN_W'(k_r) < cnt_r);
  assign adv       = !emit_step || !oval_r || out_ready;

  always_comb begin
    logic prt;
    prt = ((in_data.key_char >= 8'd32) && (in_data.key_char <= 8'd126)) ||
          (in_data.key_char >= 8'd128);
    st_nxt    = st_r;
    k_nxt     = k_r;
    len_nxt   = len_r;
    cur_nxt   = cur_r;
    mode_nxt  = mode_r;
    mlen_nxt  = mlen_r;
    mcur_nxt  = mcur_r;
    cnt_nxt   = cnt_r;
    mmode_nxt = mmode_r;
    mfin_nxt  = mfin_r;
    mcan_nxt  = mcan_r;
    oval_nxt  = oval_r && !out_ready;
    odat_nxt  = odat_r;
    ctl       = '{op: OP_HOLD, pos: '0, ch: in_data.key_char};

    if (in_fire) begin
      unique case (in_data.cmd)
        CMD_CHAR: begin
          if (prt) begin
            if (!mode_r) begin
              if (len_r < lim) begin
                ctl.op  = OP_INS;
                ctl.pos = cur_r;
                len_nxt = len_r + 1'b1;
                cur_nxt = cur_r + 1'b1;
              end
            end else if (cur_r < len_r) begin
              ctl.op  = OP_WR;
              ctl.pos = cur_r;
              cur_nxt = cur_r + 1'b1;
            end else if (len_r < lim) begin
              ctl.op  = OP_WR;
              ctl.pos = len_r;
              len_nxt = len_r + 1'b1;
              cur_nxt = len_r + 1'b1;
            end
          end
        end
        CMD_LEFT:  if (cur_r != '0) cur_nxt = cur_r - 1'b1;
        CMD_RIGHT: if (cur_r < len_r) cur_nxt = cur_r + 1'b1;
        CMD_HOME:  cur_nxt = '0;
        CMD_END:   cur_nxt = len_r;
        CMD_BKSP: begin
          if (cur_r != '0) begin
            ctl.op  = OP_DEL;
            ctl.pos = cur_r - 1'b1;
            cur_nxt = cur_r - 1'b1;
            len_nxt = len_r - 1'b1;
          end
        end
        CMD_DEL: begin
          if (cur_r < len_r) begin
            ctl.op  = OP_DEL;
            ctl.pos = cur_r;
            len_nxt = len_r - 1'b1;
          end
        end
        CMD_MODE:  mode_nxt = !mode_r;
        CMD_ESC: begin
          len_nxt  = '0;
          cur_nxt  = '0;
          mode_nxt = 1'b0;
        end
        CMD_ENTER: ;
        default: ;
      endcase
      mlen_nxt  = len_nxt;
      mcur_nxt  = cur_nxt;
      mmode_nxt = mode_nxt;
      mfin_nxt  = (in_data.cmd == CMD_ESC) || (in_data.cmd == CMD_ENTER);
      mcan_nxt  = (in_data.cmd == CMD_ESC);
      cnt_nxt   = (len_nxt == '0) ? LEN_W'(1) : len_nxt;
      if (in_data.cmd == CMD_ENTER) begin
        len_nxt  = '0;
        cur_nxt  = '0;
        mode_nxt = 1'b0;
      end
      st_nxt = ST_ROT;
      k_nxt  = '0;
    end else if (st_r == ST_ROT && adv) begin
      ctl.op  = OP_DEL;
      ctl.pos = '0;
      k_nxt   = k_r + 1'b1;
      if (k_r == K_LAST) st_nxt = ST_IDLE;
      if (emit_step) begin
        oval_nxt                = 1'b1;
        odat_nxt.char_value     = (mlen_r == '0) ? '0 : head;
        odat_nxt.char_valid     = (mlen_r != '0);
        odat_nxt.is_last        = (LEN_W'(k_r) + 1'b1 == cnt_r);
        odat_nxt.cursor_pos     = mcur_r;
        odat_nxt.text_length    = mlen_r;
        odat_nxt.overwrite_mode = mmode_r;
        odat_nxt.finished       = mfin_r;
        odat_nxt.cancelled      = mcan_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      k_r      <= '0;
      len_r    <= '0;
      cur_r    <= '0;
      mode_r   <= 1'b0;
      maxlen_r <= LEN_W'(64);
      cnt_r    <= '0;
      oval_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      k_r    <= k_nxt;
      len_r  <= len_nxt;
      cur_r  <= cur_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      oval_r <= oval_nxt;
      if (cfg_we) maxlen_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mlen_r  <= mlen_nxt;
    mcur_r  <= mcur_nxt;
    mmode_r <= mmode_nxt;
    mfin_r  <= mfin_nxt;
    mcan_r  <= mcan_nxt;
    odat_r  <= odat_nxt;
  end

  assign out_valid = oval_r;
  assign out_data  = odat_r;

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= DEPTH_L) else $error("line length beyond depth");
  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r) else $error("cursor beyond line end");
  a_esc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.cmd == CMD_ESC) |=> (len_r == '0 && cur_r == '0 && !mode_r))
    else $error("escape left line state");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROT && emit_step && oval_r && !out_ready) |=> $stable(k_r))
    else $error("rotation advanced under output stall");
`endif

endmodule
`default_nettype wire
